/* rtl/core/cfau_pkg.sv */
// ----------------------------------------------------------------------------
// cfau_pkg: shared types and constants
// Operation codes and sequencer states for the float arithmetic unit.
// ----------------------------------------------------------------------------
package cfau_pkg;

    localparam int MANT_W = 64;
    localparam int EXP_W  = 32;
    localparam int CUT_SHIFT = 31;
    localparam logic [EXP_W-1:0] POINT_POS = 32'd62;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_I2F = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADD,
        ST_MUL,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/custom_float_arith_unit.sv */
// ----------------------------------------------------------------------------
// custom_float_arith_unit: non-IEEE float add/sub/mul/div/int-to-float
// Iterative unit: one shared shift/add datapath under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the operands and i_func and raise start while busy is low; the item
//   is taken at that edge and busy rises on the next cycle.
//   The result appears on o_r_* for exactly one cycle with o_valid high.
//   The receiver cannot stall; it must capture the result in that cycle.
// Steps per operation (from accept to the o_valid cycle):
//   add/sub: alignment one bit per cycle (up to 64 bits), then normalization.
//   multiply: 33 shift-add steps over the 33-bit truncated multiplier.
//   divide: 64 restoring steps, one quotient bit each.
//   normalization: one bit shift per cycle.
//   The shared 66-bit adder/shifter bounds the rate; one item at a time, and
//   a divide whose shifted divisor is zero goes straight to the result.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
//   drops busy and o_valid; nothing else is held.
// Unused codes give sign 0, mantissa 0, exponent 0.
// ----------------------------------------------------------------------------
module custom_float_arith_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic        i_a_sign,
    input  logic [63:0] i_a_mantissa,
    input  logic signed [31:0] i_a_exponent,
    input  logic        i_b_sign,
    input  logic [63:0] i_b_mantissa,
    input  logic signed [31:0] i_b_exponent,
    output logic        o_valid,
    output logic        o_r_sign,
    output logic [63:0] o_r_mantissa,
    output logic signed [31:0] o_r_exponent
);
    import cfau_pkg::*;

    t_state r_state, n_state;
    logic        r_as, n_as, r_bs, n_bs, r_sign, n_sign;
    logic [63:0] r_am, n_am, r_bm, n_bm;
    logic [65:0] r_acc, n_acc;      // working mantissa incl. carry/product bits
    logic [63:0] r_rem, n_rem;      // divide remainder / multiply multiplier
    logic [31:0] r_exp, n_exp;
    logic [32:0] r_diff, n_diff;    // alignment shift count
    logic [6:0]  r_cnt, n_cnt;
    logic        r_swap, n_swap;
    logic        r_valid, n_valid;

    logic [64:0] w_trial;
    logic [63:0] w_dv;
    logic [32:0] w_d;

    assign w_dv = r_bm >> CUT_SHIFT;
    assign w_d  = {r_exp[31], r_exp} - {r_diff[31], r_diff[31:0]};
    assign w_trial = {r_rem, r_am[63]} - {1'b0, w_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_as <= n_as; r_bs <= n_bs; r_sign <= n_sign;
        r_am <= n_am; r_bm <= n_bm; r_acc <= n_acc; r_rem <= n_rem;
        r_exp <= n_exp; r_diff <= n_diff; r_cnt <= n_cnt; r_swap <= n_swap;
    end

    always_comb begin
        n_state = r_state; n_as = r_as; n_bs = r_bs;
        n_sign = r_sign; n_am = r_am; n_bm = r_bm; n_acc = r_acc;
        n_rem = r_rem; n_exp = r_exp; n_diff = r_diff; n_cnt = r_cnt;
        n_swap = r_swap; n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_as = i_a_sign; n_am = i_a_mantissa;
                    n_bm = i_b_mantissa; n_exp = i_a_exponent;
                    n_diff = {1'b0, i_b_exponent};
                    n_bs = (i_func == OP_SUB) ? ~i_b_sign : i_b_sign;
                    n_acc = '0; n_sign = 1'b0; n_cnt = '0; n_rem = '0;
                    case (i_func)
                        OP_ADD, OP_SUB: n_state = ST_ALIGN;
                        OP_MUL: begin
                            n_state = ST_MUL;
                            n_am = i_a_mantissa >> CUT_SHIFT;
                            n_rem = i_b_mantissa >> CUT_SHIFT;
                            n_sign = i_a_sign ^ i_b_sign;
                            n_exp = i_a_exponent + i_b_exponent;
                        end
                        OP_DIV: begin
                            n_state = ST_DIV;
                            n_sign = i_a_sign ^ i_b_sign;
                            n_exp = i_a_exponent - i_b_exponent + 32'(CUT_SHIFT);
                        end
                        OP_I2F: begin
                            n_state = ST_NORM;
                            n_acc = {2'b00, i_a_mantissa};
                            n_exp = (i_a_mantissa == '0) ? '0 : POINT_POS;
                        end
                        default: begin
                            n_state = ST_DONE;
                            n_exp = '0;
                        end
                    endcase
                end
            end
            ST_ALIGN: begin
                // signed exponent difference, then shift smaller operand
                n_swap = w_d[32];
                n_diff = w_d[32] ? -w_d : w_d;
                if (w_d[32]) n_exp = r_diff[31:0];
                n_state = ST_ADD;
                n_cnt = '0;
            end
            ST_ADD: begin
                if (r_diff != '0 && (r_swap ? r_am : r_bm) != '0) begin
                    if (r_swap) n_am = r_am >> 1;
                    else        n_bm = r_bm >> 1;
                    n_diff = r_diff - 33'd1;
                end else begin
                    if (r_as == r_bs) begin
                        n_acc = {2'b00, r_am} + {2'b00, r_bm};
                        n_sign = r_as;
                    end else if (r_am > r_bm) begin
                        n_acc = {2'b00, r_am - r_bm};
                        n_sign = r_as;
                    end else begin
                        n_acc = {2'b00, r_bm - r_am};
                        n_sign = r_bs;
                    end
                    n_state = ST_NORM;
                end
            end
            ST_MUL: begin
                // 33x33 shift-add, multiplier bits LSB first, full product in acc
                if (r_cnt == 7'd33) begin
                    n_state = ST_NORM;
                end else begin
                    n_acc = r_rem[r_cnt[5:0]] ?
                            r_acc + ({2'b00, r_am} << r_cnt[5:0]) : r_acc;
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_DIV: begin
                if (w_dv == '0) begin
                    n_sign = 1'b0; n_exp = '0; n_acc = '0;
                    n_state = ST_DONE;
                end else if (r_cnt == 7'd64) begin
                    n_state = ST_NORM;
                end else begin
                    if (!w_trial[64]) begin
                        n_rem = w_trial[63:0];
                        n_acc = {r_acc[64:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[62:0], r_am[63]};
                        n_acc = {r_acc[64:0], 1'b0};
                    end
                    n_am = r_am << 1;
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_NORM: begin
                if (r_acc[65:63] != 3'b000) begin
                    n_acc = r_acc >> 1;
                    n_exp = r_exp + 32'd1;
                end else if (r_acc != '0 && !r_acc[62]) begin
                    n_acc = r_acc << 1;
                    n_exp = r_exp - 32'd1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_r_sign     = r_sign;
    assign o_r_mantissa = r_acc[63:0];
    assign o_r_exponent = r_exp;

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_valid) else $error("result strobe missing");
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_r_mantissa == '0 || o_r_mantissa[63:62] == 2'b01))
        else $error("result not normalized");
    a_idle_after_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy with result");

endmodule
